// ----- design/mpfr_pkg.sv -----
// ============================================================================
// mpfr_pkg
// Shared types and constants for the monochrome page framebuffer refresh unit.
// ============================================================================
`default_nettype none

package mpfr_pkg;

    // Request codes carried in the req_type field of an input item.
    localparam logic [1:0] REQ_DRAW    = 2'd0;
    localparam logic [1:0] REQ_FILL    = 2'd1;
    localparam logic [1:0] REQ_REFRESH = 2'd2;
    localparam logic [1:0] REQ_TICK    = 2'd3;

    // Panel command bytes sent at the head of every page, and the two fill bytes.
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] BYTE_ALL_ON   = 8'hFF;
    localparam logic [7:0] BYTE_ALL_OFF  = 8'h00;

    // Widest byte address over the whole supported panel range (255 x 31 bytes).
    localparam int ADDR_MAX_W = 13;
    localparam int PAGE_W     = 5;
    localparam int POS_W      = 9;

    // Depth of the operation queue between front and back end.
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_PTR_W = 2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  pix_x;
        logic [7:0]  pix_y;
        logic [15:0] color;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_done;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_FILL,
        OP_CMD,
        OP_DATA
    } op_kind_t;

    // One classified operation for the back end.
    // val:  bit mask for a draw, fill byte for a fill, command byte for a command.
    // flag: pixel on for a draw, last byte of the frame for a data read.
    typedef struct packed {
        op_kind_t               kind;
        logic [ADDR_MAX_W-1:0]  addr;
        logic [7:0]             val;
        logic                   flag;
    } op_t;

endpackage

`default_nettype wire

// ----- design/mono_page_framebuffer_refresh_unit.sv -----
// ============================================================================
// mono_page_framebuffer_refresh_unit
// One-bit-per-pixel page framebuffer with byte-serial scan-out for a panel.
// ============================================================================
// Draw, refresh and tick items are taken at up to one per cycle while full is
// low: a draw is a read-modify-write through a two-stage back end with a write
// bypass, and a tick during scan-out yields one command or data byte per cycle
// as long as results are popped. A fill occupies the single memory write port,
// writing one byte per cycle, and items behind it wait in a four-entry queue.
// After reset the memory is cleared by the same sweep, during which full stays
// high.
`default_nettype none

module mono_page_framebuffer_refresh_unit #(
    parameter int DISP_WIDTH = 128,
    parameter int DISP_PAGES = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire mpfr_pkg::in_item_t req,
    output logic                    empty,
    input  wire logic               pop,
    output mpfr_pkg::out_item_t     result
);

    mpfr_pkg::op_t fe_op;
    mpfr_pkg::op_t q_head;
    logic          fe_push;
    logic          q_full, q_empty, q_pop;
    logic          clearing;

    mpfr_front #(
        .DISP_WIDTH (DISP_WIDTH),
        .DISP_PAGES (DISP_PAGES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .req     (req),
        .stall   (q_full || clearing),
        .full    (full),
        .op_push (fe_push),
        .op      (fe_op)
    );

    mpfr_op_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .wr_op (fe_op),
        .pop   (q_pop),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    mpfr_back #(
        .DISP_WIDTH (DISP_WIDTH),
        .DISP_PAGES (DISP_PAGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .clearing (clearing),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

`default_nettype wire

// ----- design/mpfr_front.sv -----
// ============================================================================
// mpfr_front
// Accepts items, tracks the scan-out position and turns draw, fill and scan-out
// tick items into operations for the back end.
// ============================================================================
`default_nettype none

module mpfr_front #(
    parameter int DISP_WIDTH = 128,
    parameter int DISP_PAGES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mpfr_pkg::in_item_t req,
    input  wire logic              stall,
    output logic                   full,
    output logic                   op_push,
    output mpfr_pkg::op_t          op
);

    localparam int ADDR_W = $clog2(DISP_WIDTH * DISP_PAGES);

    localparam logic [7:0]                  WIDTH_L   = 8'(DISP_WIDTH);
    localparam logic [mpfr_pkg::PAGE_W-1:0] PAGES_L   = mpfr_pkg::PAGE_W'(DISP_PAGES);
    localparam logic [mpfr_pkg::PAGE_W-1:0] PAGE_LAST = mpfr_pkg::PAGE_W'(DISP_PAGES - 1);
    localparam logic [mpfr_pkg::POS_W-1:0]  POS_LAST  = mpfr_pkg::POS_W'(DISP_WIDTH + 2);
    localparam logic [mpfr_pkg::POS_W-1:0]  POS_CMD0  = mpfr_pkg::POS_W'(0);
    localparam logic [mpfr_pkg::POS_W-1:0]  POS_CMD1  = mpfr_pkg::POS_W'(1);
    localparam logic [mpfr_pkg::POS_W-1:0]  POS_CMD2  = mpfr_pkg::POS_W'(2);

    logic                        busy_reg, busy_next;
    logic [mpfr_pkg::PAGE_W-1:0] page_reg, page_next;
    logic [mpfr_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0]           scan_addr_reg, scan_addr_next;

    logic                        accept;
    logic [4:0]                  y_page;
    logic [ADDR_W-1:0]           draw_addr;
    logic                        in_range;

    assign full   = stall;
    assign accept = push && !stall;

    assign y_page    = req.pix_y[7:3];
    assign in_range  = (req.pix_x < WIDTH_L) && (y_page < PAGES_L);
    assign draw_addr = ADDR_W'(ADDR_W'(y_page) * ADDR_W'(DISP_WIDTH))
                     + ADDR_W'(req.pix_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            page_reg      <= '0;
            pos_reg       <= '0;
            scan_addr_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            page_reg      <= page_next;
            pos_reg       <= pos_next;
            scan_addr_reg <= scan_addr_next;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        page_next      = page_reg;
        pos_next       = pos_reg;
        scan_addr_next = scan_addr_reg;
        op_push        = 1'b0;
        op.kind        = mpfr_pkg::OP_CMD;
        op.addr        = '0;
        op.val         = '0;
        op.flag        = 1'b0;

        if (accept)
        begin
            unique case (req.req_type)
                mpfr_pkg::REQ_DRAW:
                begin
                    op_push = in_range;
                    op.kind = mpfr_pkg::OP_DRAW;
                    op.addr = mpfr_pkg::ADDR_MAX_W'(draw_addr);
                    op.val  = 8'(8'd1 << req.pix_y[2:0]);
                    op.flag = (req.color != 16'd0);
                end
                mpfr_pkg::REQ_FILL:
                begin
                    op_push = 1'b1;
                    op.kind = mpfr_pkg::OP_FILL;
                    op.val  = (req.color != 16'd0) ? mpfr_pkg::BYTE_ALL_ON
                                                   : mpfr_pkg::BYTE_ALL_OFF;
                end
                mpfr_pkg::REQ_REFRESH:
                begin
                    busy_next      = 1'b1;
                    page_next      = '0;
                    pos_next       = '0;
                    scan_addr_next = '0;
                end
                default:
                begin
                    if (busy_reg)
                    begin
                        op_push = 1'b1;
                        priority if (pos_reg == POS_CMD0)
                        begin
                            op.val = mpfr_pkg::CMD_PAGE_BASE + 8'(page_reg);
                        end
                        else if (pos_reg == POS_CMD1)
                        begin
                            op.val = mpfr_pkg::CMD_COL_LOW;
                        end
                        else if (pos_reg == POS_CMD2)
                        begin
                            op.val = mpfr_pkg::CMD_COL_HIGH;
                        end
                        else
                        begin
                            op.kind        = mpfr_pkg::OP_DATA;
                            op.addr        = mpfr_pkg::ADDR_MAX_W'(scan_addr_reg);
                            scan_addr_next = scan_addr_reg + ADDR_W'(1);
                        end

                        if (pos_reg == POS_LAST)
                        begin
                            pos_next = '0;
                            if (page_reg == PAGE_LAST)
                            begin
                                page_next      = '0;
                                busy_next      = 1'b0;
                                scan_addr_next = '0;
                                op.flag        = 1'b1;
                            end
                            else
                            begin
                                page_next = page_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/mpfr_op_queue.sv -----
// ============================================================================
// mpfr_op_queue
// Short first-in first-out queue of operations between front and back end.
// ============================================================================
`default_nettype none

module mpfr_op_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mpfr_pkg::op_t wr_op,
    input  wire logic          pop,
    output mpfr_pkg::op_t      head,
    output logic               full,
    output logic               empty
);

    localparam int CNT_W = mpfr_pkg::OPQ_PTR_W + 1;

    mpfr_pkg::op_t                  entry_reg [mpfr_pkg::OPQ_DEPTH];
    logic [mpfr_pkg::OPQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(mpfr_pkg::OPQ_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

`default_nettype wire

// ----- design/mpfr_back.sv -----
// ============================================================================
// mpfr_back
// Holds the framebuffer memory and carries out draws, fills and scan-out
// reads, delivering result items through a two-entry output buffer.
// ============================================================================
`default_nettype none

module mpfr_back #(
    parameter int DISP_WIDTH = 128,
    parameter int DISP_PAGES = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mpfr_pkg::op_t head,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               clearing,
    output mpfr_pkg::out_item_t result,
    output logic               empty,
    input  wire logic          pop
);

    localparam int MEM_BYTES = DISP_WIDTH * DISP_PAGES;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MEM_BYTES - 1);

    logic [7:0] mem [MEM_BYTES];

    // Fill sweep; reset starts one with a zero byte to clear the memory.
    logic              fill_active_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] fill_addr_reg;
    logic [7:0]        fill_val_reg;

    // Second stage: operation whose memory read is in flight.
    logic              b_valid_reg, b_valid_next;
    mpfr_pkg::op_t     b_op_reg;
    logic [7:0]        rdata_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;

    mpfr_pkg::out_item_t out0_reg, out1_reg;
    logic [1:0]          out_cnt_reg, out_cnt_next;

    logic              head_ok, rd_en, fill_start, b_finish, out_full;
    logic              b_we, b_out, o_push, o_pop;
    logic [7:0]        b_data, b_wdata;
    logic [ADDR_W-1:0] head_addr, b_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    mpfr_pkg::out_item_t b_result;

    assign head_addr = head.addr[ADDR_W-1:0];
    assign b_addr    = b_op_reg.addr[ADDR_W-1:0];
    assign clearing  = clearing_reg;

    assign out_full = (out_cnt_reg == 2'd2);
    assign empty    = (out_cnt_reg == 2'd0);
    assign result   = out0_reg;
    assign o_pop    = pop && !empty;

    // A write from the last stage lands in the same cycle as a new read, so
    // the read of that address picks the written byte from the bypass.
    assign b_data = fwd_hit_reg ? fwd_data_reg : rdata_reg;

    always_comb
    begin
        b_we          = 1'b0;
        b_out         = 1'b0;
        b_wdata       = b_data;
        b_result.out_byte   = b_op_reg.val;
        b_result.is_data    = 1'b0;
        b_result.frame_done = 1'b0;
        if (b_valid_reg)
        begin
            unique case (b_op_reg.kind)
                mpfr_pkg::OP_DRAW:
                begin
                    b_we    = 1'b1;
                    b_wdata = b_op_reg.flag ? (b_data | b_op_reg.val)
                                            : (b_data & ~b_op_reg.val);
                end
                mpfr_pkg::OP_DATA:
                begin
                    b_out               = 1'b1;
                    b_result.out_byte   = b_data;
                    b_result.is_data    = 1'b1;
                    b_result.frame_done = b_op_reg.flag;
                end
                mpfr_pkg::OP_CMD:
                begin
                    b_out = 1'b1;
                end
                default:
                begin
                    b_out = 1'b0;
                end
            endcase
        end
    end

    assign b_finish = !(b_out && out_full);
    assign o_push   = b_out && !out_full;

    // A fill waits until the last stage is empty so the sweep owns the write port.
    assign head_ok    = !q_empty && !fill_active_reg && b_finish;
    assign q_pop      = head_ok && ((head.kind != mpfr_pkg::OP_FILL) || !b_valid_reg);
    assign fill_start = q_pop && (head.kind == mpfr_pkg::OP_FILL);
    assign rd_en      = q_pop && ((head.kind == mpfr_pkg::OP_DRAW)
                                  || (head.kind == mpfr_pkg::OP_DATA));

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_finish)
        begin
            b_valid_next = q_pop && (head.kind != mpfr_pkg::OP_FILL);
        end
    end

    assign mem_we    = fill_active_reg || b_we;
    assign mem_waddr = fill_active_reg ? fill_addr_reg : b_addr;
    assign mem_wdata = fill_active_reg ? fill_val_reg : b_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[head_addr];
            fwd_hit_reg  <= b_we && (b_addr == head_addr);
            fwd_data_reg <= b_wdata;
        end
        if (b_finish && q_pop)
        begin
            b_op_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b1;
            clearing_reg    <= 1'b1;
            fill_addr_reg   <= '0;
            fill_val_reg    <= mpfr_pkg::BYTE_ALL_OFF;
            b_valid_reg     <= 1'b0;
            out_cnt_reg     <= '0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            out_cnt_reg <= out_cnt_next;
            if (fill_active_reg)
            begin
                if (fill_addr_reg == ADDR_LAST)
                begin
                    fill_active_reg <= 1'b0;
                    clearing_reg    <= 1'b0;
                end
                else
                begin
                    fill_addr_reg <= fill_addr_reg + 1'b1;
                end
            end
            else if (fill_start)
            begin
                fill_active_reg <= 1'b1;
                fill_addr_reg   <= '0;
                fill_val_reg    <= head.val;
            end
        end
    end

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (o_push && !o_pop)
        begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end
        else if (o_pop && !o_push)
        begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    // The new item goes to the head slot when the buffer is empty or its only
    // entry leaves in the same cycle; otherwise it queues behind the head.
    always_ff @(posedge clk)
    begin
        if (o_push && ((out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && o_pop)))
        begin
            out0_reg <= b_result;
        end
        else if (o_pop)
        begin
            out0_reg <= out1_reg;
        end
        if (o_push && (out_cnt_reg == 2'd1) && !o_pop)
        begin
            out1_reg <= b_result;
        end
    end

endmodule

`default_nettype wire
